FILE: rtl/core/sirrd_pkg.sv
// Shared constants, register indexes and control/status types for the
// signed integer to radix digits block. No dependencies.
package sirrd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W     = $clog2(VALUE_BITS);
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = VALUE_BITS / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int ALPH_PER_W = CFG_W / CHAR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIG_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIG_HI  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RST  = 5'd10;
    localparam logic [CFG_W-1:0]   DIG_LO_RST = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   DIG_HI_RST = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_commit;
        logic zero_digit;
        logic sign_load;
        logic char_load;
    } t_cmd;

    typedef struct packed {
        logic alpha_ok;
        logic mag_zero;
        logic quo_zero;
        logic cnt_full;
        logic neg;
        logic out_taken;
        logic out_last;
    } t_sts;

endpackage

FILE: rtl/core/sirrd_ctrl.sv
// Sequencer for the radix conversion: check, digit division loop, beat output.
// Depends on sirrd_pkg.
module sirrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sirrd_pkg::t_sts   i_sts,
    output sirrd_pkg::t_cmd   o_cmd
);
    import sirrd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_last_step;

    assign w_last_step = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_ready     = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.alpha_ok) begin
                    n_state = S_IDLE;
                end else if (i_sts.mag_zero) begin
                    o_cmd.zero_digit = 1'b1;
                    n_state          = i_sts.neg ? S_SIGN : S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (w_last_step) begin
                    o_cmd.div_commit = 1'b1;
                    if (i_sts.quo_zero || i_sts.cnt_full) begin
                        n_state = i_sts.neg ? S_SIGN : S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_SIGN: begin
                o_cmd.sign_load = 1'b1;
                n_state         = S_WAIT;
            end
            S_LOAD: begin
                o_cmd.char_load = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.out_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

FILE: rtl/core/sirrd_dp.sv
// Datapath: config registers, alphabet check, digit divider, digit store,
// output register. Depends on sirrd_pkg.
module sirrd_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sirrd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sirrd_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [sirrd_pkg::VALUE_BITS-1:0] i_value,
    input  sirrd_pkg::t_cmd                      i_cmd,
    output sirrd_pkg::t_sts                      o_sts,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic [sirrd_pkg::CHAR_W-1:0]         o_character,
    output logic                                 o_last
);
    import sirrd_pkg::*;

    logic [RADIX_W-1:0]    r_radix;
    logic [CFG_W-1:0]      r_dig_lo;
    logic [CFG_W-1:0]      r_dig_hi;

    logic [VALUE_BITS-1:0] r_work, n_work;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;

    logic [DIGIT_W-1:0]    mem_digit [VALUE_BITS];
    logic [DIGIT_W-1:0]    r_rdata;
    logic [ADDR_W-1:0]     w_rd_addr;

    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;
    logic                  r_out_valid;

    logic [CHAR_W-1:0]     w_alph [MAX_RADIX];
    logic                  w_alpha_ok;
    logic [VALUE_BITS-1:0] w_val;
    logic [VALUE_BITS-1:0] w_mag;

    // alphabet bytes and validity
    always_comb begin
        for (int i = 0; i < ALPH_PER_W; i++) begin
            w_alph[i]              = r_dig_lo[i*CHAR_W +: CHAR_W];
            w_alph[i + ALPH_PER_W] = r_dig_hi[i*CHAR_W +: CHAR_W];
        end
    end

    always_comb begin
        w_alpha_ok = (r_radix >= RADIX_W'(2)) && (r_radix <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            if (RADIX_W'(i) < r_radix) begin
                if (w_alph[i] == CHAR_NUL || w_alph[i] == CHAR_MINUS ||
                    w_alph[i] == CHAR_PLUS) begin
                    w_alpha_ok = 1'b0;
                end
                for (int j = 0; j < i; j++) begin
                    if (w_alph[j] == w_alph[i]) begin
                        w_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // one quotient byte per cycle, remainder stays below the radix
    always_comb begin
        logic [DIGIT_W:0]    t;
        logic [DIV_BITS-1:0] q;
        logic [DIV_BITS-1:0] chunk;
        logic [DIGIT_W-1:0]  rem;
        chunk = r_work[VALUE_BITS-1 -: DIV_BITS];
        rem   = r_rem;
        q     = '0;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            t = {rem, chunk[b]};
            if (t >= r_radix) begin
                t    = t - r_radix;
                q[b] = 1'b1;
            end
            rem = t[DIGIT_W-1:0];
        end
        n_rem  = rem;
        n_work = {r_work[VALUE_BITS-DIV_BITS-1:0], q};
    end

    assign w_val     = $unsigned(i_value);
    assign w_mag     = w_val[VALUE_BITS-1] ? (VALUE_BITS'(0) - w_val) : w_val;
    assign w_rd_addr = ADDR_W'(r_cnt - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RST;
            r_dig_lo <= DIG_LO_RST;
            r_dig_hi <= DIG_HI_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIX:  r_radix  <= i_cfg_data[RADIX_W-1:0];
                CFG_DIG_LO: r_dig_lo <= i_cfg_data;
                CFG_DIG_HI: r_dig_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_neg  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_work <= w_mag;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_neg  <= w_val[VALUE_BITS-1];
            end else if (i_cmd.div_step) begin
                r_work <= n_work;
                r_rem  <= i_cmd.div_commit ? '0 : n_rem;
                if (i_cmd.div_commit) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (i_cmd.zero_digit) begin
                r_cnt <= CNT_W'(1);
            end else if (i_cmd.char_load) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_commit) begin
            mem_digit[r_cnt[ADDR_W-1:0]] <= n_rem;
        end else if (i_cmd.zero_digit) begin
            mem_digit[r_cnt[ADDR_W-1:0]] <= '0;
        end
        r_rdata <= mem_digit[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sign_load) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.char_load) begin
            r_char <= w_alph[r_rdata];
            r_last <= (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.sign_load || i_cmd.char_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    assign o_sts.alpha_ok  = w_alpha_ok;
    assign o_sts.mag_zero  = (r_work == '0);
    assign o_sts.quo_zero  = (n_work == '0);
    assign o_sts.cnt_full  = (r_cnt == CNT_W'(VALUE_BITS - 1));
    assign o_sts.neg       = r_neg;
    assign o_sts.out_taken = r_out_valid & i_ready;
    assign o_sts.out_last  = r_last;

endmodule

FILE: rtl/core/signed_integer_to_radix_digits.sv
// Signed 32-bit value to text in a configurable radix of 2 to 16, most
// significant digit first, with a leading '-' for negative values. After a
// value is accepted, the alphabet is checked first (an invalid one ends the
// item there, with no beats). Each digit is then found in the divider, which
// works through 8 bits of the 32-bit magnitude per cycle, a full pass over the
// magnitude per digit. The digits are then sent one beat at a time from the
// digit store, each beat held until the sink takes it. The next value is taken
// once the beat marked last has gone. Zero gives the single digit-0 character.
// Depends on sirrd_pkg, sirrd_ctrl and sirrd_dp.
module signed_integer_to_radix_digits (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [sirrd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [sirrd_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [sirrd_pkg::VALUE_BITS-1:0] i_value,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [sirrd_pkg::CHAR_W-1:0]            o_character,
    output logic                                    o_last
);
    import sirrd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sirrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sirrd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/core/sirrd_chk.sv
// Port-level checks for signed_integer_to_radix_digits, bound to the top level.
// Depends on sirrd_pkg.
module sirrd_chk (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_valid,
    input logic                                    o_ready,
    input logic                                    o_valid,
    input logic                                    i_ready,
    input logic [sirrd_pkg::CHAR_W-1:0]            o_character,
    input logic                                    o_last
);
    import sirrd_pkg::*;

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a beat is pending");

    a_busy_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a value was taken");

    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_character != CHAR_NUL)
        else $error("NUL character sent");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == CHAR_MINUS |-> !o_last)
        else $error("minus sign marked last");

endmodule

bind signed_integer_to_radix_digits sirrd_chk u_sirrd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);
